### rtl/core/sbls_pkg.sv
package sbls_pkg;

	// Field widths
	localparam int unsigned LIGHT_W  = 20;
	localparam int unsigned CORNER_W = 14;
	localparam int unsigned ADDR_W   = 14;
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned LEVEL_W  = 6;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned MIP_W    = 2;
	localparam int unsigned IN_DATA_W = 88;

	// Input item kinds
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEXEL = 2'd2;

	// Light step shift at mip level zero
	localparam logic [2:0] SHIFT_BASE = 3'd4;

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	// One request from front to back: a colormap write or a colormap lookup
	typedef struct packed {
		logic              is_write;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  value;
		logic              row_end;
		logic              block_end;
	} req_t;

	// Queue status toward the top level
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/core/sbls_front.sv
module sbls_front #(
	parameter int unsigned LIGHT_LEVELS   = 64,
	parameter int unsigned BLOCK_EDGE_MAX = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sbls_pkg::MIP_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	input  logic [sbls_pkg::MODE_W-1:0]         in_mode,
	input  logic [sbls_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                q_full,
	output logic                                push,
	output sbls_pkg::req_t                      push_req
);
	import sbls_pkg::*;

	localparam int unsigned CNT_W = (BLOCK_EDGE_MAX > 1) ? $clog2(BLOCK_EDGE_MAX) : 1;
	localparam int unsigned CMP_W = CNT_W + 1;
	localparam logic [CMP_W-1:0] EDGE_MAX = CMP_W'(BLOCK_EDGE_MAX);
	localparam logic [LEVEL_W:0] LEVEL_LIMIT = (LEVEL_W + 1)'(LIGHT_LEVELS);
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LIGHT_LEVELS - 1);

	logic [MIP_W-1:0]          mip_q;
	logic signed [LIGHT_W-1:0] left_light_q, right_light_q;
	logic signed [LIGHT_W-1:0] left_step_q, right_step_q;
	logic signed [LIGHT_W-1:0] run_light_q, run_step_q;
	logic [CNT_W-1:0]          col_q, row_q;

	logic                      accept;
	logic [2:0]                shift;
	logic [ADDR_W-1:0]         tbl_index;
	logic [PIX_W-1:0]          tbl_value;
	logic [CORNER_W-1:0]       c_tl, c_tr, c_bl, c_br;
	logic [PIX_W-1:0]          texel;
	logic signed [LIGHT_W-1:0] tl, tr, bl, br;
	logic signed [LIGHT_W-1:0] new_left, new_right;
	logic [LEVEL_W-1:0]        level;
	logic [CMP_W-1:0]          edge_len, col_next, row_next;
	logic                      row_end, block_end;

	// Unpack the data word
	assign tbl_index = in_data[13:0];
	assign tbl_value = in_data[21:14];
	assign c_tl      = in_data[35:22];
	assign c_tr      = in_data[49:36];
	assign c_bl      = in_data[63:50];
	assign c_br      = in_data[77:64];
	assign texel     = in_data[85:78];

	assign tl = LIGHT_W'(c_tl);
	assign tr = LIGHT_W'(c_tr);
	assign bl = LIGHT_W'(c_bl);
	assign br = LIGHT_W'(c_br);

	assign accept = in_valid && !q_full;
	assign shift  = SHIFT_BASE - {1'b0, mip_q};

	// Saturate the light level taken from bits 13..8
	always_comb begin
		level = run_light_q[13:8];
		if ({1'b0, level} >= LEVEL_LIMIT) begin
			level = LEVEL_TOP;
		end
	end

	// Block edge length and end-of-row / end-of-block tests
	always_comb begin
		edge_len = EDGE_MAX >> mip_q;
		if (edge_len == '0) begin
			edge_len = CMP_W'(1);
		end
		col_next  = {1'b0, col_q} + CMP_W'(1);
		row_next  = {1'b0, row_q} + CMP_W'(1);
		row_end   = col_next >= edge_len;
		block_end = row_end && (row_next >= edge_len);
	end

	assign new_left  = left_light_q + left_step_q;
	assign new_right = right_light_q + right_step_q;

	// Forward colormap writes and lookups to the back
	always_comb begin
		push              = accept && (in_mode == MODE_LOAD || in_mode == MODE_TEXEL);
		push_req.is_write = in_mode == MODE_LOAD;
		push_req.addr     = (in_mode == MODE_LOAD) ? tbl_index : {level, texel};
		push_req.value    = tbl_value;
		push_req.row_end  = row_end;
		push_req.block_end = block_end;
	end

	// Hold the mip level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mip_q <= '0;
		end else if (cfg_wr_en) begin
			mip_q <= cfg_wr_data;
		end
	end

	// Advance the interpolation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_light_q  <= '0;
			right_light_q <= '0;
			left_step_q   <= '0;
			right_step_q  <= '0;
			run_light_q   <= '0;
			run_step_q    <= '0;
			col_q         <= '0;
			row_q         <= '0;
		end else if (accept) begin
			case (in_mode)
				MODE_START: begin
					left_light_q  <= tl;
					right_light_q <= tr;
					left_step_q   <= (bl - tl) >>> shift;
					right_step_q  <= (br - tr) >>> shift;
					run_light_q   <= tr;
					run_step_q    <= (tl - tr) >>> shift;
					col_q         <= '0;
					row_q         <= '0;
				end
				MODE_TEXEL: begin
					if (row_end) begin
						col_q         <= '0;
						row_q         <= block_end ? '0 : row_next[CNT_W-1:0];
						left_light_q  <= new_left;
						right_light_q <= new_right;
						run_light_q   <= new_right;
						run_step_q    <= (new_left - new_right) >>> shift;
					end else begin
						col_q       <= col_next[CNT_W-1:0];
						run_light_q <= run_light_q + run_step_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/sbls_queue.sv
module sbls_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sbls_pkg::req_t     push_req,
	input  logic               pop,
	output sbls_pkg::req_t     head,
	output sbls_pkg::q_stat_t  stat
);
	import sbls_pkg::*;

	localparam logic [QPTR_W:0] COUNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

	req_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign stat.full  = count_q == COUNT_FULL;
	assign stat.empty = count_q == '0;
	assign head       = slot_q[rd_ptr_q];

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/sbls_back.sv
module sbls_back #(
	parameter int unsigned LIGHT_LEVELS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  sbls_pkg::req_t              head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbls_pkg::PIX_W-1:0]  out_pixel,
	output logic                        out_row_end,
	output logic                        out_block_end
);
	import sbls_pkg::*;

	localparam int unsigned MEM_DEPTH = LIGHT_LEVELS * 256;
	localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
	localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_DEPTH);

	logic [PIX_W-1:0] cmap_mem [MEM_DEPTH];
	logic [PIX_W-1:0] pixel_s1;
	logic             row_end_s1, block_end_s1, valid_s1;
	logic             take_read, do_write;

	// Writes always drain; a lookup waits for a free output slot
	assign pop       = q_valid && (head.is_write || !valid_s1 || out_ready);
	assign take_read = pop && !head.is_write;
	assign do_write  = pop && head.is_write && ({1'b0, head.addr} < MEM_LIMIT);

	// Colormap store: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_write) begin
			cmap_mem[head.addr[MEM_AW-1:0]] <= head.value;
		end
		if (take_read) begin
			pixel_s1     <= cmap_mem[head.addr[MEM_AW-1:0]];
			row_end_s1   <= head.row_end;
			block_end_s1 <= head.block_end;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_read) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign out_valid     = valid_s1;
	assign out_pixel     = pixel_s1;
	assign out_row_end   = row_end_s1;
	assign out_block_end = block_end_s1;

endmodule

### rtl/core/surface_block_light_shader.sv
// With an empty queue, an accepted texel request is written to the queue, then its colormap
//   read is registered in the back end's output stage and held there until m_tready.
// Throughput: one request per cycle while the queue is not full, set by the single
//   colormap port in the back end; each texel, block start or colormap load is one request.
// The four-entry queue between front and back absorbs short output stalls.
// Reset (arst_n low) clears the light state, counters, mip level, queue and output valid;
//   colormap contents are undefined until loaded.
module surface_block_light_shader #(
	parameter int unsigned LIGHT_LEVELS   = 64,
	parameter int unsigned BLOCK_EDGE_MAX = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sbls_pkg::MIP_W-1:0]        cfg_wr_data,   // mip_level
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// table_index, table_value, corner_top_left, corner_top_right,
	// corner_bottom_left, corner_bottom_right, texel, zero pad
	input  logic [sbls_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic [sbls_pkg::MODE_W-1:0]       s_tuser,       // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sbls_pkg::PIX_W-1:0]        m_tdata,       // shaded_pixel
	output logic                              m_tlast,       // row_end
	output logic                              m_tuser        // block_end
);
	import sbls_pkg::*;

	logic    push, pop;
	req_t    push_req, head;
	q_stat_t q_stat;

	assign s_tready = !q_stat.full;

	sbls_front #(
		.LIGHT_LEVELS   (LIGHT_LEVELS),
		.BLOCK_EDGE_MAX (BLOCK_EDGE_MAX)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_tvalid),
		.in_mode     (s_tuser),
		.in_data     (s_tdata),
		.q_full      (q_stat.full),
		.push        (push),
		.push_req    (push_req)
	);

	sbls_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	sbls_back #(
		.LIGHT_LEVELS (LIGHT_LEVELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (!q_stat.empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_pixel     (m_tdata),
		.out_row_end   (m_tlast),
		.out_block_end (m_tuser)
	);

`ifndef ASSERT_OFF
	// End of block only on the last texel of a row
	a_block_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser || m_tlast))
		else $error("block end without row end");

	// Queue cannot be full and empty at once
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue status inconsistent");

	// A stalled output keeps a pending lookup in the queue
	a_lookup_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && !q_stat.empty && !head.is_write) |=> !q_stat.empty)
		else $error("lookup left queue while output stalled");
`endif

endmodule

### tb/tb_surface_block_light_shader.sv
`timescale 1ns / 100ps

module tb_surface_block_light_shader;

	import sbls_pkg::*;

	localparam int unsigned LIGHT_LEVELS   = 64;
	localparam int unsigned BLOCK_EDGE_MAX = 16;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned END_CYCLES     = 16;
	localparam int unsigned LONG_HOLD      = 250;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASE_REQUESTS = 100;

	// Input request fields as packed on s_tdata, highest field first
	typedef struct packed {
		logic [1:0]          pad;
		logic [PIX_W-1:0]    texel;
		logic [CORNER_W-1:0] bottom_right;
		logic [CORNER_W-1:0] bottom_left;
		logic [CORNER_W-1:0] top_right;
		logic [CORNER_W-1:0] top_left;
		logic [PIX_W-1:0]    value;
		logic [ADDR_W-1:0]   index;
	} shade_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             row_end;
		logic             block_end;
	} shaded_t;

	// Shading predictor plus the queue of pixels still owed by the block
	class shade_scoreboard;
		logic [PIX_W-1:0]   colormap [16384];
		bit                 loaded [16384];
		logic [LIGHT_W-1:0] left_light, right_light, left_step, right_step;
		logic [LIGHT_W-1:0] run_light, run_step;
		int unsigned        col_cnt, row_cnt;
		logic [MIP_W-1:0]   mip;
		shaded_t            owed_q [$];
		int unsigned        errors;

		function new();
			left_light  = '0;
			right_light = '0;
			left_step   = '0;
			right_step  = '0;
			run_light   = '0;
			run_step    = '0;
			col_cnt     = 0;
			row_cnt     = 0;
			mip         = '0;
			errors      = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function logic [LIGHT_W-1:0] shift_down(input logic [LIGHT_W-1:0] diff);
			logic signed [LIGHT_W-1:0] sdiff;
			sdiff = diff;
			return sdiff >>> (SHIFT_BASE - mip);
		endfunction

		function int unsigned block_edge();
			int unsigned e;
			e = BLOCK_EDGE_MAX >> mip;
			return (e == 0) ? 1 : e;
		endfunction

		// Colormap address the next texel will read
		function logic [ADDR_W-1:0] texel_addr(input logic [PIX_W-1:0] tx);
			int unsigned      level;
			logic [LEVEL_W-1:0] lvl;
			level = run_light[8 +: LEVEL_W];
			lvl = (level >= LIGHT_LEVELS) ? LEVEL_W'(LIGHT_LEVELS - 1) : LEVEL_W'(level);
			return {lvl, tx};
		endfunction

		function void begin_row();
			run_light = right_light;
			run_step  = shift_down(left_light - right_light);
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		// Apply one accepted request: a colormap load, a block start, or a texel and its owed pixel
		function void note_request(input logic [MODE_W-1:0] mode, input shade_req_t f);
			int unsigned edge_len;
			shaded_t     px;
			case (mode)
				MODE_LOAD: begin
					colormap[f.index] = f.value;
					loaded[f.index]   = 1'b1;
				end
				MODE_START: begin
					left_light  = LIGHT_W'(f.top_left);
					right_light = LIGHT_W'(f.top_right);
					left_step   = shift_down(LIGHT_W'(f.bottom_left) - LIGHT_W'(f.top_left));
					right_step  = shift_down(LIGHT_W'(f.bottom_right) - LIGHT_W'(f.top_right));
					begin_row();
					col_cnt = 0;
					row_cnt = 0;
				end
				MODE_TEXEL: begin
					edge_len     = block_edge();
					px.pixel     = colormap[texel_addr(f.texel)];
					px.row_end   = (col_cnt + 1 >= edge_len);
					px.block_end = px.row_end && (row_cnt + 1 >= edge_len);
					owed_q.push_back(px);
					if (px.row_end) begin
						col_cnt     = 0;
						row_cnt     = px.block_end ? 0 : ((row_cnt + 1) & 5'h1f);
						left_light  = left_light + left_step;
						right_light = right_light + right_step;
						begin_row();
					end else begin
						col_cnt   = (col_cnt + 1) & 5'h1f;
						run_light = run_light + run_step;
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted pixel with the oldest one owed
		function void check_pixel(input logic [PIX_W-1:0] pix, input logic rend, input logic bend);
			shaded_t px;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected pixel %h row_end %b block_end %b", $time, pix, rend, bend);
				errors++;
				return;
			end
			px = owed_q.pop_front();
			if (pix !== px.pixel) begin
				$display("%0t: shaded_pixel expected %h actual %h", $time, px.pixel, pix);
				errors++;
			end
			if (rend !== px.row_end) begin
				$display("%0t: row_end expected %b actual %b", $time, px.row_end, rend);
				errors++;
			end
			if (bend !== px.block_end) begin
				$display("%0t: block_end expected %b actual %b", $time, px.block_end, bend);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [MIP_W-1:0]     cfg_wr_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [MODE_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [PIX_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;

	shade_scoreboard board;
	int unsigned     requests_sent;
	int unsigned     burst_left;
	bit              long_hold_req;

	surface_block_light_shader #(
		.LIGHT_LEVELS   (LIGHT_LEVELS),
		.BLOCK_EDGE_MAX (BLOCK_EDGE_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Random content for every field, pad held at zero
	function automatic shade_req_t noise_fields();
		shade_req_t f;
		f.pad          = '0;
		f.texel        = $urandom_range(0, 255);
		f.bottom_right = $urandom_range(0, 16383);
		f.bottom_left  = $urandom_range(0, 16383);
		f.top_right    = $urandom_range(0, 16383);
		f.top_left     = $urandom_range(0, 16383);
		f.value        = $urandom_range(0, 255);
		f.index        = $urandom_range(0, 16383);
		return f;
	endfunction

	function automatic logic [CORNER_W-1:0] pick_corner();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom_range(0, 16383);
		endcase
	endfunction

	// Offer one request, hold it until accepted, then pace the next one
	task automatic push_request(input logic [MODE_W-1:0] mode, input shade_req_t f);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= f;
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note_request(mode, f);
		if (mode != MODE_UNUSED) requests_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                          : $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_load(input logic [ADDR_W-1:0] idx, input logic [PIX_W-1:0] val);
		shade_req_t f;
		f = noise_fields();
		f.index = idx;
		f.value = val;
		push_request(MODE_LOAD, f);
	endtask

	task automatic send_start(input logic [CORNER_W-1:0] tl, input logic [CORNER_W-1:0] tr,
	                          input logic [CORNER_W-1:0] bl, input logic [CORNER_W-1:0] br);
		shade_req_t f;
		f = noise_fields();
		f.top_left     = tl;
		f.top_right    = tr;
		f.bottom_left  = bl;
		f.bottom_right = br;
		push_request(MODE_START, f);
	endtask

	// Load the entry this texel will read first if it was never written
	task automatic send_texel(input logic [PIX_W-1:0] tx);
		shade_req_t        f;
		logic [ADDR_W-1:0] addr;
		addr = board.texel_addr(tx);
		if (!board.loaded[addr]) send_load(addr, $urandom_range(0, 255));
		f = noise_fields();
		f.texel = tx;
		push_request(MODE_TEXEL, f);
	endtask

	task automatic send_unused();
		push_request(MODE_UNUSED, noise_fields());
	endtask

	// Stream texels with an occasional stray load or unused request mixed in
	task automatic shade_run(input int unsigned n);
		repeat (n) begin
			case ($urandom_range(0, 39))
				0:       send_load($urandom_range(0, 16383), $urandom_range(0, 255));
				1:       send_unused();
				default: ;
			endcase
			send_texel($urandom_range(0, 255));
		end
	endtask

	// Drop valid and wait for every owed pixel plus the pipeline tail
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mip(input logic [MIP_W-1:0] lvl);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lvl;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.mip = lvl;
	endtask

	task automatic run_phase(input int unsigned target);
		int unsigned goal, edge_len, n, sel;
		goal = requests_sent + target;
		// continue the open block under the new mip level
		shade_run($urandom_range(1, 5));
		while (requests_sent < goal) begin
			edge_len = board.block_edge();
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				send_start(pick_corner(), pick_corner(), pick_corner(), pick_corner());
				n = edge_len * edge_len;
				case ($urandom_range(0, 9))
					0:       n = $urandom_range(1, n);
					1:       n = n + $urandom_range(1, 2 * edge_len);
					default: ;
				endcase
				shade_run(n);
			end else if (sel < 85) begin
				shade_run($urandom_range(1, 2 * edge_len));
			end else if (sel < 95) begin
				send_load($urandom_range(0, 16383), $urandom_range(0, 255));
			end else begin
				send_unused();
			end
		end
	endtask

	// Receiver: stall pattern of its own, plus one long hold on request
	initial begin : rx_side
		int unsigned seg_left, style, hold_left;
		seg_left  = 0;
		style     = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				board.check_pixel(m_tdata, m_tlast, m_tuser);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(16, 128);
					style    = $urandom_range(0, 3);
				end
				seg_left--;
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= $urandom_range(0, 1);
					2:       m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run after a long stretch with no handshake on either side
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
			    (m_tvalid === 1'b1 && m_tready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_surface_block_light_shader: errors");
		$finish;
	end

	initial begin : stimulus
		logic [MIP_W-1:0] mip_plan [8];
		board         = new();
		requests_sent = 0;
		burst_left    = 0;
		long_hold_req = 1'b0;
		mip_plan      = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table extremes, then texels on the reset light state
		send_load('0, '0);
		send_load('1, '1);
		send_texel('0);
		send_texel('1);
		send_unused();
		// steep gradients with negative steps
		send_start('0, '1, '1, '0);
		repeat (4) send_texel($urandom_range(0, 255));
		// brightest corners reach the top light level
		send_start('1, '1, '1, '1);
		send_texel('1);
		send_texel('0);
		// light rising from zero along the row, with the left edge falling down the block
		send_start('1, '0, '0, '1);
		repeat (3) send_texel($urandom_range(0, 255));

		// random phases across mip levels, one with a long output hold
		foreach (mip_plan[p]) begin
			write_mip(mip_plan[p]);
			if (p == 2) long_hold_req = 1'b1;
			run_phase(PHASE_REQUESTS);
		end

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_surface_block_light_shader: clean");
		else
			$display("tb_surface_block_light_shader: errors");
		$finish;
	end

endmodule
